// ===== rtl/core/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// Shared codes, item and result types of the instruction executor.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam logic [4:0] KIND_NOP  = 5'd0;
  localparam logic [4:0] KIND_ADD  = 5'd1;
  localparam logic [4:0] KIND_SUB  = 5'd2;
  localparam logic [4:0] KIND_SW   = 5'd3;
  localparam logic [4:0] KIND_LW   = 5'd4;
  localparam logic [4:0] KIND_LI   = 5'd5;
  localparam logic [4:0] KIND_J    = 5'd6;
  localparam logic [4:0] KIND_ADDI = 5'd7;
  localparam logic [4:0] KIND_MOVE = 5'd8;
  localparam logic [4:0] KIND_ADDU = 5'd9;
  localparam logic [4:0] KIND_MUL  = 5'd10;
  localparam logic [4:0] KIND_AND  = 5'd11;
  localparam logic [4:0] KIND_ANDI = 5'd12;
  localparam logic [4:0] KIND_NOR  = 5'd13;
  localparam logic [4:0] KIND_OR   = 5'd14;
  localparam logic [4:0] KIND_XOR  = 5'd15;
  localparam logic [4:0] KIND_XORI = 5'd16;
  localparam logic [4:0] KIND_BEQ  = 5'd17;
  localparam logic [4:0] KIND_BLT  = 5'd18;
  localparam logic [4:0] KIND_BLE  = 5'd19;
  localparam logic [4:0] KIND_BGT  = 5'd20;
  localparam logic [4:0] KIND_BGE  = 5'd21;
  localparam logic [4:0] KIND_BNE  = 5'd22;

  localparam logic [4:0]  REG_PC  = 5'd31;
  localparam logic [31:0] PC_STEP = 32'd4;

  localparam logic [1:0] MACC_NONE  = 2'd0;
  localparam logic [1:0] MACC_STORE = 2'd1;
  localparam logic [1:0] MACC_LOAD  = 2'd2;

  localparam int unsigned QuotW = 12;

  typedef enum logic [2:0] {
    CLS_NOP,
    CLS_ALU,
    CLS_STORE,
    CLS_LOAD,
    CLS_JUMP,
    CLS_BRANCH
  } cls_e;

  typedef struct packed {
    logic [4:0]       kind;
    cls_e             cls;
    logic [4:0]       rd;
    logic [4:0]       ra;
    logic [4:0]       rb;
    logic [31:0]      imm;
    logic [11:0]      idx;
    logic [QuotW-1:0] quot;
    logic [31:0]      target;
    logic [31:0]      offset;
  } item_t;

  typedef struct packed {
    logic        reg_written;
    logic [4:0]  written_reg;
    logic [31:0] written_value;
    logic [1:0]  mem_access;
    logic [31:0] mem_word;
    logic        branch_taken;
    logic [31:0] counter_after;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic busy;
    logic start;
  } back_st_t;

endpackage

// ===== rtl/core/mips_subset_instruction_executor_core.sv =====
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor_core
// Executes decoded instructions on a register file, counter and data memory.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// request   in         push / full            kind_i .. branch_offset_i
// result    out        pop / empty            reg_written_o .. counter_after_o
//
// Each instruction is first read from the register file and data memory, then
// executed and written back; the back end starts no new instruction while one
// is executing.
// After reset a clearing pass writes zero to every data memory word, with full
// held high.
// A two-entry queue on each side lets the input and output stall separately.
// ----------------------------------------------------------------------------
module mips_subset_instruction_executor_core import mse_pkg::*; #(
  parameter int unsigned MEM_WORDS = 4096,
  parameter int unsigned REG_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [4:0]  kind_i,
  input  logic [4:0]  dest_reg_i,
  input  logic [4:0]  src_reg_a_i,
  input  logic [4:0]  src_reg_b_i,
  input  logic [31:0] immediate_i,
  input  logic [11:0] mem_index_i,
  input  logic [31:0] jump_target_i,
  input  logic [31:0] branch_offset_i,
  output logic        empty,
  input  logic        pop,
  output logic        reg_written_o,
  output logic [$clog2(REG_COUNT)-1:0] written_reg_o,
  output logic [31:0] written_value_o,
  output logic [1:0]  mem_access_o,
  output logic [31:0] mem_word_o,
  output logic        branch_taken_o,
  output logic [31:0] counter_after_o
);

  item_t    fr_item, q_item;
  logic     q_full, q_empty, q_pop;
  res_t     res, out_res;
  logic     out_push, out_full;
  back_st_t st;

  assign full = q_full || st.clearing;

  mse_front #(.MEM_WORDS(MEM_WORDS)) u_front (
    .kind_i          (kind_i),
    .dest_reg_i      (dest_reg_i),
    .src_reg_a_i     (src_reg_a_i),
    .src_reg_b_i     (src_reg_b_i),
    .immediate_i     (immediate_i),
    .mem_index_i     (mem_index_i),
    .jump_target_i   (jump_target_i),
    .branch_offset_i (branch_offset_i),
    .item_o          (fr_item)
  );

  mse_fifo #(.W($bits(item_t))) u_iq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !full),
    .data_i  (fr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_item),
    .empty_o (q_empty)
  );

  mse_back #(.MEM_WORDS(MEM_WORDS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_res_o  (res),
    .st_o       (st)
  );

  mse_fifo #(.W($bits(res_t))) u_oq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign reg_written_o   = out_res.reg_written;
  assign written_reg_o   = out_res.written_reg;
  assign written_value_o = out_res.written_value;
  assign mem_access_o    = out_res.mem_access;
  assign mem_word_o      = out_res.mem_word;
  assign branch_taken_o  = out_res.branch_taken;
  assign counter_after_o = out_res.counter_after;

`ifndef SYNTHESIS
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.clearing |-> full) else $error("input open during memory clear");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full) else $error("result queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty && !st.clearing) else $error("pop from empty queue");
  a_two_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.busy |-> !st.start) else $error("overlapping execution");
`endif

endmodule

// ===== rtl/core/mse_fifo.sv =====
// ----------------------------------------------------------------------------
// mse_fifo
// Two-entry queue with registered storage.
// ----------------------------------------------------------------------------
module mse_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  logic [W-1:0] ent_q [2];
  logic         wp_q, wp_d, rp_q, rp_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = ent_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d  = do_push ? ~wp_q : wp_q;
    rp_d  = do_pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/mse_front.sv =====
// ----------------------------------------------------------------------------
// mse_front
// Classify an incoming instruction and precompute its memory word quotient.
// ----------------------------------------------------------------------------
module mse_front import mse_pkg::*; #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic [4:0]  kind_i,
  input  logic [4:0]  dest_reg_i,
  input  logic [4:0]  src_reg_a_i,
  input  logic [4:0]  src_reg_b_i,
  input  logic [31:0] immediate_i,
  input  logic [11:0] mem_index_i,
  input  logic [31:0] jump_target_i,
  input  logic [31:0] branch_offset_i,
  output item_t       item_o
);

  localparam int unsigned Recip = ((1 << 24) + MEM_WORDS - 1) / MEM_WORDS;

  logic [32:0] prod;
  cls_e        cls;

  assign prod = 33'(mem_index_i) * 33'(Recip);

  always_comb begin
    unique case (kind_i) inside
      KIND_ADD, KIND_SUB, KIND_LI, KIND_ADDI, KIND_MOVE, KIND_ADDU, KIND_MUL,
      KIND_AND, KIND_ANDI, KIND_NOR, KIND_OR, KIND_XOR, KIND_XORI: cls = CLS_ALU;
      KIND_SW:                                                     cls = CLS_STORE;
      KIND_LW:                                                     cls = CLS_LOAD;
      KIND_J:                                                      cls = CLS_JUMP;
      KIND_BEQ, KIND_BLT, KIND_BLE, KIND_BGT, KIND_BGE, KIND_BNE:  cls = CLS_BRANCH;
      default:                                                     cls = CLS_NOP;
    endcase
  end

  always_comb begin
    item_o.kind   = kind_i;
    item_o.cls    = cls;
    item_o.rd     = dest_reg_i;
    item_o.ra     = src_reg_a_i;
    item_o.rb     = src_reg_b_i;
    item_o.imm    = immediate_i;
    item_o.idx    = mem_index_i;
    item_o.quot   = QuotW'(prod[32:24]);
    item_o.target = jump_target_i;
    item_o.offset = branch_offset_i;
  end

endmodule

// ===== rtl/core/mse_back.sv =====
// ----------------------------------------------------------------------------
// mse_back
// Execute instructions on the register file, counter and data memory, after a
// clearing pass that writes zero to the data memory after reset.
module mse_back import mse_pkg::*; #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  item_t    q_item_i,
  output logic     q_pop_o,
  input  logic     out_full_i,
  output logic     out_push_o,
  output res_t     out_res_o,
  output back_st_t st_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [31:0]   rf_q [32];
  logic [31:0]   rf_vld_q;
  logic [31:0]   mem [MEM_WORDS];
  logic [31:0]   pc_q, pc_d;
  logic          busy_q;
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;
  logic          start;

  item_t         ex_q;
  logic [31:0]   va_q, vb_q, rdata_q;
  logic [AW-1:0] addr_q;

  logic signed [31:0] rem_raw, rem;
  logic [AW-1:0]      addr;

  logic        wr, cond, taken, mem_we;
  logic [31:0] wval, mword, pc_base;
  logic [1:0]  macc;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wd;

  assign start   = !clr_q && !busy_q && !q_empty_i && !out_full_i;
  assign q_pop_o = start;
  assign st_o    = '{clearing: clr_q, busy: busy_q, start: start};

  assign rem_raw = $signed({20'd0, q_item_i.idx}) -
                   $signed(32'(q_item_i.quot) * 32'(MEM_WORDS));
  assign rem     = (rem_raw < 0) ? rem_raw + 32'(MEM_WORDS) : rem_raw;
  assign addr    = rem[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      pc_q      <= '0;
      rf_vld_q  <= '0;
    end else begin
      busy_q <= start;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(MEM_WORDS - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (busy_q) begin
        pc_q <= pc_d;
        if (wr && ex_q.rd != REG_PC) begin
          rf_vld_q[ex_q.rd] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      ex_q   <= q_item_i;
      addr_q <= addr;
      va_q   <= (q_item_i.ra == REG_PC) ? pc_q :
                (rf_vld_q[q_item_i.ra] ? rf_q[q_item_i.ra] : '0);
      vb_q   <= (q_item_i.rb == REG_PC) ? pc_q :
                (rf_vld_q[q_item_i.rb] ? rf_q[q_item_i.rb] : '0);
    end
    if (busy_q && wr && ex_q.rd != REG_PC) begin
      rf_q[ex_q.rd] <= wval;
    end
  end

  assign mem_we = clr_q || (busy_q && ex_q.cls == CLS_STORE);
  assign mem_wa = clr_q ? clr_cnt_q : addr_q;
  assign mem_wd = clr_q ? '0 : va_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (start) begin
      rdata_q <= mem[addr];
    end
  end

  always_comb begin
    wr   = (ex_q.cls == CLS_ALU) || (ex_q.cls == CLS_LOAD);
    wval = '0;
    cond = 1'b0;
    unique case (ex_q.kind) inside
      KIND_ADD, KIND_ADDU: wval = va_q + vb_q;
      KIND_SUB:            wval = va_q - vb_q;
      KIND_LW:             wval = rdata_q;
      KIND_LI:             wval = ex_q.imm;
      KIND_ADDI:           wval = va_q + ex_q.imm;
      KIND_MOVE:           wval = va_q;
      KIND_MUL:            wval = 32'(va_q * vb_q);
      KIND_AND:            wval = va_q & vb_q;
      KIND_ANDI:           wval = va_q & ex_q.imm;
      KIND_NOR:            wval = ~(va_q | vb_q);
      KIND_OR:             wval = va_q | vb_q;
      KIND_XOR:            wval = va_q ^ vb_q;
      KIND_XORI:           wval = va_q ^ ex_q.imm;
      KIND_BEQ:            cond = (va_q == vb_q);
      KIND_BLT:            cond = ($signed(va_q) < $signed(vb_q));
      KIND_BLE:            cond = ($signed(va_q) <= $signed(vb_q));
      KIND_BGT:            cond = ($signed(va_q) > $signed(vb_q));
      KIND_BGE:            cond = ($signed(va_q) >= $signed(vb_q));
      KIND_BNE:            cond = (va_q != vb_q);
      default:             wval = '0;
    endcase
  end

  always_comb begin
    taken = (ex_q.cls == CLS_JUMP) || (ex_q.cls == CLS_BRANCH && cond);
    macc  = MACC_NONE;
    mword = '0;
    if (ex_q.cls == CLS_STORE) begin
      macc  = MACC_STORE;
      mword = va_q;
    end else if (ex_q.cls == CLS_LOAD) begin
      macc  = MACC_LOAD;
      mword = rdata_q;
    end
    if (wr && ex_q.rd == REG_PC) begin
      pc_base = wval;
    end else if (ex_q.cls == CLS_JUMP) begin
      pc_base = ex_q.target;
    end else if (taken) begin
      pc_base = pc_q + ex_q.offset;
    end else begin
      pc_base = pc_q;
    end
    pc_d = pc_base + PC_STEP;
  end

  assign out_push_o                = busy_q;
  assign out_res_o.reg_written     = wr;
  assign out_res_o.written_reg     = wr ? ex_q.rd : '0;
  assign out_res_o.written_value   = wr ? wval : '0;
  assign out_res_o.mem_access      = macc;
  assign out_res_o.mem_word        = mword;
  assign out_res_o.branch_taken    = taken;
  assign out_res_o.counter_after   = pc_d;

endmodule
